/* hdl/fd_pkg.sv */
`timescale 1ns / 1ps
// Package for the filtered derivative block: widths, register indexes,
// sequencer state type and the rounding and saturation helper.
package fd_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned GainWidth  = 16;
  localparam int unsigned MagWidth   = DataWidth + 1;
  localparam int unsigned ChunkWidth = 16;
  localparam int unsigned ProdWidth  = MagWidth + ChunkWidth;
  localparam int unsigned AccWidth   = MagWidth + DataWidth;
  localparam int unsigned QuotWidth  = AccWidth - ChunkWidth;

  // Configuration register indexes.
  localparam logic RegSmoothingGain = 1'b0;
  localparam logic RegInvPeriod     = 1'b1;

  // Half an LSB of the Q16.16 result, added before the truncating shift.
  localparam logic [AccWidth-1:0] RoundHalf = AccWidth'(64'h8000);

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StMulLo  = 7'b0000010,
    StMulHi  = 7'b0000100,
    StErr    = 7'b0001000,
    StMulG   = 7'b0010000,
    StUpdate = 7'b0100000,
    StResult = 7'b1000000
  } fd_state_e;

  // Applies the sign to a rounded magnitude and saturates it to 32 bits.
  function automatic logic [DataWidth-1:0] round_sat(input logic neg,
                                                     input logic [QuotWidth-1:0] q);
    logic [QuotWidth-1:0] lim;
    logic [DataWidth-1:0] mag;
    begin
      if (neg) begin
        lim = QuotWidth'(64'h8000_0000);
      end else begin
        lim = QuotWidth'(64'h7FFF_FFFF);
      end
      mag = (q > lim) ? lim[DataWidth-1:0] : q[DataWidth-1:0];
      round_sat = neg ? (~mag + DataWidth'(1)) : mag;
    end
  endfunction

endpackage

/* hdl/filtered_derivative.sv */
`timescale 1ns / 1ps
// Filtered derivative: rate estimate from successive samples, smoothed by a
// one-pole low-pass. Depends on fd_pkg.
// Before the filter has started, a request goes straight to the result state;
// otherwise it uses the shared 33x16 multiplier three times in turn.
// The input stalls while the sequencer is busy, so a request is taken only
// once the last is done; a finished result waits in its own output register.
// Reset clears both registers, the previous sample, the filter state and
// the started flag, and empties the output register.
module filtered_derivative
  import fd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [DataWidth-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [DataWidth-1:0] sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [DataWidth-1:0] rate_o
);

  fd_state_e state_q, state_d;

  logic [GainWidth-1:0] gain_q;
  logic [DataWidth-1:0] inv_period_q;
  logic [DataWidth-1:0] prev_q;
  logic [DataWidth-1:0] filt_q, filt_d;
  logic                 started_q, started_d;
  logic                 neg_q, neg_d;
  logic [MagWidth-1:0]  mag_q, mag_d;
  logic [AccWidth-1:0]  acc_q, acc_d;
  logic [DataWidth-1:0] result_q, result_d;
  logic                 out_valid_q, out_valid_d;
  logic [DataWidth-1:0] rate_q, rate_d;

  logic                 in_req;
  logic [MagWidth-1:0]  diff;
  logic [MagWidth-1:0]  err;
  logic [DataWidth-1:0] raw;
  logic [DataWidth-1:0] delta;
  logic [MagWidth-1:0]  y_sum;
  logic [DataWidth-1:0] y_sat;
  logic [ChunkWidth-1:0] mul_b;
  logic [ProdWidth-1:0] prod;

  assign in_stall_o  = (state_q != StIdle);
  assign in_req      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign rate_o      = rate_q;

  // Sample difference, exact in 33 bits.
  assign diff = {sample_i[DataWidth-1], sample_i} - {prev_q[DataWidth-1], prev_q};

  // Shared multiplier: magnitude times one 16-bit coefficient chunk.
  always_comb begin
    case (state_q)
      StMulLo: mul_b = inv_period_q[ChunkWidth-1:0];
      StMulHi: mul_b = inv_period_q[DataWidth-1:ChunkWidth];
      default: mul_b = gain_q;
    endcase
  end
  assign prod = ProdWidth'(mag_q) * ProdWidth'(mul_b);

  // Raw rate, filter error and filter update from the accumulator.
  assign raw   = round_sat(neg_q, acc_q[AccWidth-1:ChunkWidth]);
  assign err   = {raw[DataWidth-1], raw} - {filt_q[DataWidth-1], filt_q};
  assign delta = round_sat(neg_q, acc_q[AccWidth-1:ChunkWidth]);
  assign y_sum = {filt_q[DataWidth-1], filt_q} + {delta[DataWidth-1], delta};

  // Clamp the updated filter value to 32 bits.
  always_comb begin
    if (y_sum[MagWidth-1] != y_sum[DataWidth-1]) begin
      y_sat = y_sum[MagWidth-1] ? {1'b1, {(DataWidth-1){1'b0}}}
                                : {1'b0, {(DataWidth-1){1'b1}}};
    end else begin
      y_sat = y_sum[DataWidth-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    filt_d      = filt_q;
    started_d   = started_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    acc_d       = acc_q;
    result_d    = result_q;
    out_valid_d = out_valid_q && out_stall_i;
    rate_d      = rate_q;
    case (state_q)
      StIdle: begin
        if (in_req) begin
          neg_d    = diff[MagWidth-1];
          mag_d    = diff[MagWidth-1] ? (~diff + MagWidth'(1)) : diff;
          result_d = '0;
          if (started_q) begin
            state_d = StMulLo;
          end else begin
            if ((gain_q != '0) && (inv_period_q != '0)) begin
              filt_d    = '0;
              started_d = 1'b1;
            end
            state_d = StResult;
          end
        end
      end
      StMulLo: begin
        acc_d   = RoundHalf + AccWidth'(prod);
        state_d = StMulHi;
      end
      StMulHi: begin
        acc_d   = acc_q + (AccWidth'(prod) << ChunkWidth);
        state_d = StErr;
      end
      StErr: begin
        neg_d   = err[MagWidth-1];
        mag_d   = err[MagWidth-1] ? (~err + MagWidth'(1)) : err;
        state_d = StMulG;
      end
      StMulG: begin
        acc_d   = RoundHalf + AccWidth'(prod);
        state_d = StUpdate;
      end
      StUpdate: begin
        filt_d   = y_sat;
        result_d = y_sat;
        state_d  = StResult;
      end
      StResult: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          rate_d      = result_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      started_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      gain_q       <= '0;
      inv_period_q <= '0;
      prev_q       <= '0;
      filt_q       <= '0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
      filt_q      <= filt_d;
      if (in_req) begin
        prev_q <= sample_i;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegSmoothingGain: gain_q       <= cfg_data_i[GainWidth-1:0];
          RegInvPeriod:     inv_period_q <= cfg_data_i;
          default:          gain_q       <= gain_q;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    acc_q    <= acc_d;
    result_q <= result_d;
    rate_q   <= rate_d;
  end

endmodule

/* dv/tb_filtered_derivative.sv */
`timescale 1ns / 1ps
// Self-checking testbench for filtered_derivative: drives samples and register
// writes, predicts every filtered rate and compares it. Depends on fd_pkg.
module tb_filtered_derivative;
  import fd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned HoldCycles = 400;

  // Predicts the filtered rate for each accepted request and keeps the
  // expected values in arrival order.
  class rate_scoreboard;
    logic [GainWidth-1:0]        gain;
    logic [DataWidth-1:0]        inv_period;
    logic signed [DataWidth-1:0] prev_sample;
    logic signed [DataWidth-1:0] filt_rate;
    bit                          started;
    logic signed [DataWidth-1:0] rate_q[$];
    int unsigned                 errors;

    function new();
      gain        = '0;
      inv_period  = '0;
      prev_sample = '0;
      filt_rate   = '0;
      started     = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic idx, logic [DataWidth-1:0] data);
      if (idx == RegSmoothingGain) begin
        gain = data[GainWidth-1:0];
      end else begin
        inv_period = data;
      end
    endfunction

    // Rounds a Q.32 magnitude to Q16.16, ties away from zero, and saturates.
    function longint round_sat(bit neg, longint unsigned mag);
      longint unsigned q;
      q = (mag + 64'h8000) >> 16;
      if (neg) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return -longint'(q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return longint'(q);
    endfunction

    function void note_sample(logic signed [DataWidth-1:0] s);
      longint          diff;
      longint          raw;
      longint          err;
      longint          y;
      longint unsigned dmag;
      longint unsigned emag;
      y = 0;
      if (started) begin
        diff = longint'(s) - longint'(prev_sample);
        dmag = (diff < 0) ? -diff : diff;
        raw  = round_sat(diff < 0, dmag * longint'(inv_period));
        err  = raw - longint'(filt_rate);
        emag = (err < 0) ? -err : err;
        y    = longint'(filt_rate) + round_sat(err < 0, emag * longint'(gain));
        if (y > longint'(32'sh7FFF_FFFF)) y = longint'(32'sh7FFF_FFFF);
        if (y < longint'(32'sh8000_0000)) y = longint'(32'sh8000_0000);
        filt_rate = y[DataWidth-1:0];
      end else if (gain != 0 && inv_period != 0) begin
        // The first request with both registers set only primes the filter.
        filt_rate = '0;
        started   = 1'b1;
      end
      prev_sample = s;
      rate_q.push_back(y[DataWidth-1:0]);
    endfunction

    function void check_rate(logic signed [DataWidth-1:0] got);
      logic signed [DataWidth-1:0] want;
      if (rate_q.size() == 0) begin
        $error("rate: no result expected, actual %0d", got);
        errors++;
        return;
      end
      want = rate_q.pop_front();
      if (want !== got) begin
        $error("rate: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return rate_q.size();
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic                        cfg_index_i = 1'b0;
  logic [DataWidth-1:0]        cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic signed [DataWidth-1:0] sample_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [DataWidth-1:0] rate_o;

  rate_scoreboard              sb = new();
  bit                          calm = 1'b0;
  bit                          hold_request = 1'b0;
  int unsigned                 hold_left = 0;
  int unsigned                 cycle_count = 0;
  logic signed [DataWidth-1:0] last_sample = '0;

  filtered_derivative dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .rate_o     (rate_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Inputs only change at the rising edge, so the falling edge sees exactly
  // the values that the next rising edge will act on.
  always @(negedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_sample(sample_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_rate(rate_o);
  end

  // Receiver: random stalls, quiet stretches and one long hold-off.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 17);
    end
  end

  // Offers one request and returns right after the edge that accepts it.
  task automatic send_sample(input logic signed [DataWidth-1:0] s);
    bit took;
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= s;
    last_sample = s;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  // Waits until every result is back and the block has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [DataWidth-1:0] data);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly slow ramps with noise, plus full-range values and extremes.
  function automatic logic signed [DataWidth-1:0] pick_sample();
    int          span;
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom;
    if (sel == 1) begin
      case ($urandom_range(3))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return '0;
        default: return '1;
      endcase
    end
    span = 1 << $urandom_range(4, 24);
    return last_sample + (int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic [DataWidth-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h0000_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DataWidth-1:0] pick_inv_period();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0001_0000;
      4:       return 32'h0000_0001 << $urandom_range(10, 24);
      default: return $urandom;
    endcase
  endfunction

  // Cycle counter that ends a run which has stopped making progress.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both registers still zero after reset: outputs stay at zero.
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh0000_0000);
    send_sample(-32'sd1);
    // Gain set but period zero; the upper data bits must be dropped.
    write_reg(RegSmoothingGain, 32'hABCD_FFFF);
    send_sample(32'sd100);
    send_sample(-32'sd100);
    // Period set but gain zero.
    write_reg(RegSmoothingGain, 32'h0);
    write_reg(RegInvPeriod, 32'h0000_8000);
    send_sample(32'sd7);
    // Both set: the first request starts the filter, then ties round away.
    write_reg(RegSmoothingGain, 32'h0000_8000);
    send_sample(32'sd0);
    send_sample(32'sd1);
    send_sample(32'sd0);
    send_sample(-32'sd1);
    // Largest steps with the largest settings saturate both ways.
    write_reg(RegSmoothingGain, 32'h0000_FFFF);
    write_reg(RegInvPeriod, 32'hFFFF_FFFF);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    // A zero gain once started holds the filter.
    write_reg(RegSmoothingGain, 32'h0);
    send_sample(32'sd5);
    send_sample(32'sh8000_0000);
    // A zero period once started decays the filter towards zero.
    write_reg(RegSmoothingGain, 32'h0000_FFFF);
    write_reg(RegInvPeriod, 32'h0);
    send_sample(32'sd9);
    send_sample(-32'sd9);
    // Smallest nonzero settings.
    write_reg(RegSmoothingGain, 32'h0000_0001);
    write_reg(RegInvPeriod, 32'h0000_0001);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh0000_1234);

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(RegSmoothingGain, pick_gain());
      write_reg(RegInvPeriod, pick_inv_period());
      calm = (phase == 2);
      if (phase == 5) hold_request = 1'b1;
      for (int n = 0; n < 100; n++) send_sample(pick_sample());
    end
    calm = 1'b0;

    settle();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
